>>> rtl/pcm_frame_to_s16_stereo_unit_defines.svh
// assertion macros for the pcm frame converter top level
`ifndef PCM_FRAME_TO_S16_STEREO_UNIT_DEFINES_SVH
`define PCM_FRAME_TO_S16_STEREO_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define PF2S_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define PF2S_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pf2s_pkg.sv
// shared types and constants for the pcm frame to s16 stereo converter
`default_nettype none

package pf2s_pkg;

   // sample format codes
   localparam logic [2:0] FMT_FLOAT32 = 3'd0;
   localparam logic [2:0] FMT_PCM16   = 3'd1;
   localparam logic [2:0] FMT_PCM24   = 3'd2;
   localparam logic [2:0] FMT_PCM32   = 3'd3;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_SOURCE = 2'd1;

   // largest output magnitude
   localparam logic [14:0] SAMPLE_MAX = 15'h7FFF;

   // decoded sample: value = mant * 2^-shift, mant normalized to bit 23
   typedef struct packed {
      logic        neg;
      logic        zero;
      logic        sat;
      logic [23:0] mant;
      logic [7:0]  shift;
   } dec_type;

endpackage

`default_nettype wire

>>> rtl/pcm_frame_to_s16_stereo_unit.sv
// top level of the pcm frame to s16 stereo converter
//
// Request channel (req_): one audio frame per transfer, the raw first and
// second channel sample words plus the packet end mark.
// Response channel (rsp_): one signed 16-bit stereo pair per frame, with the
// packet end mark copied through.
// Configuration channel (csr_): index 0 selects the sample format (float32,
// pcm16, pcm24, pcm32, other codes give silence), index 1 selects a stereo
// source (1) or a mono source that drives both outputs (0). csr_ready is
// always high; the user must let writes go in only while no frame is in flight,
// as the block itself does not enforce it. A frame passes a decode stage
// (format decode, leading one search, 24-bit rounding) and then a scale
// stage (product by 32767, rounding, truncation, clamp), each registered.
// Throughput is one frame per cycle while the receiver keeps rsp_stall low.
// When the receiver stalls, the response register holds its frame and the
// decode stage still takes one more frame; req_stall rises only when both
// stages are full.
// Synchronous reset empties both stages and sets float32 with a stereo source.
`default_nettype none

module pcm_frame_to_s16_stereo_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [31:0]                       req_first_raw,
   input  logic [31:0]                       req_second_raw,
   input  logic                              req_packet_end,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_left_sample,
   output logic signed [15:0]                rsp_right_sample,
   output logic                              rsp_packet_end_out,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pf2s_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pf2s_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pf2s_pkg::*;

   `include "pcm_frame_to_s16_stereo_unit_defines.svh"

   logic [2:0]         sample_format_ff;
   logic               stereo_source_ff;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   dec_type            s1_left_ff;
   dec_type            s1_right_ff;
   logic               s1_end_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [15:0] rsp_left_ff;
   logic signed [15:0] rsp_right_ff;
   logic               rsp_end_ff;
   logic               s2_ready;
   logic               s1_ready;
   logic               req_xfer;
   logic               csr_xfer;
   logic [31:0]        right_raw;
   dec_type            dec_left;
   dec_type            dec_right;
   logic signed [15:0] scaled_left;
   logic signed [15:0] scaled_right;

   // handshake control
   assign s2_ready    = !rsp_valid_ff || !rsp_stall;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign req_stall   = !s1_ready;
   assign req_xfer    = req_valid && s1_ready;
   assign csr_ready   = 1'b1;
   assign csr_xfer    = csr_valid && csr_ready;
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= FMT_FLOAT32;
         stereo_source_ff <= 1'b1;
      end else if (csr_xfer) begin
         if (csr_index == CSR_SAMPLE_FORMAT) begin
            sample_format_ff <= csr_wdata[2:0];
         end else if (csr_index == CSR_STEREO_SOURCE) begin
            stereo_source_ff <= csr_wdata[0];
         end
      end
   end

   // mono source feeds the first channel to both sides
   assign right_raw = stereo_source_ff ? req_second_raw : req_first_raw;

   pf2s_decode u_dec_left (
      .fmt (sample_format_ff),
      .raw (req_first_raw),
      .dec (dec_left)
   );

   pf2s_decode u_dec_right (
      .fmt (sample_format_ff),
      .raw (right_raw),
      .dec (dec_right)
   );

   // decode stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_left_ff  <= dec_left;
         s1_right_ff <= dec_right;
         s1_end_ff   <= req_packet_end;
      end
   end

   pf2s_scale u_scale_left (
      .dec    (s1_left_ff),
      .sample (scaled_left)
   );

   pf2s_scale u_scale_right (
      .dec    (s1_right_ff),
      .sample (scaled_right)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         rsp_left_ff  <= scaled_left;
         rsp_right_ff <= scaled_right;
         rsp_end_ff   <= s1_end_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_sample    = rsp_left_ff;
   assign rsp_right_sample   = rsp_right_ff;
   assign rsp_packet_end_out = rsp_end_ff;

   // checks on the pipeline and the output clamp
   `PF2S_ASSERT_NEXT(a_req_enters_s1, clock, reset, req_xfer, s1_valid_ff, "accepted frame lost before decode stage")
   `PF2S_ASSERT_NEXT(a_s1_moves_out, clock, reset, s1_valid_ff && s2_ready, rsp_valid_ff, "decoded frame not moved to response register")
   `PF2S_ASSERT_NOW(a_left_clamped, clock, reset, rsp_valid_ff, rsp_left_ff != 16'sh8000, "left sample outside clamp range")
   `PF2S_ASSERT_NOW(a_right_clamped, clock, reset, rsp_valid_ff, rsp_right_ff != 16'sh8000, "right sample outside clamp range")

endmodule

`default_nettype wire

>>> rtl/pf2s_decode.sv
// decodes one raw sample word into a normalized 24-bit mantissa and exponent
`default_nettype none

module pf2s_decode (
   input  logic [2:0]        fmt,
   input  logic [31:0]       raw,
   output pf2s_pkg::dec_type dec
);
   import pf2s_pkg::*;

   logic [7:0]  exp_f;
   logic [31:0] mag_x;
   logic [7:0]  base_shift;
   logic [4:0]  lz;
   logic [31:0] norm_x;
   logic        round_up;
   logic [24:0] rounded;
   logic [8:0]  shift_full;
   logic [15:0] mag16;
   logic [23:0] mag24;
   logic        dec_neg;
   logic        dec_zero;
   logic        dec_sat;
   logic [23:0] dec_mant;
   logic [7:0]  dec_shift;

   // format decode into a magnitude word and its binary point
   always_comb begin
      exp_f      = raw[30:23];
      mag16      = raw[15] ? (~raw[15:0] + 16'd1) : raw[15:0];
      mag24      = raw[23] ? (~raw[23:0] + 24'd1) : raw[23:0];
      mag_x      = '0;
      base_shift = '0;
      dec_neg    = 1'b0;
      dec_zero   = 1'b0;
      dec_sat    = 1'b0;
      unique case (fmt)
         FMT_FLOAT32: begin
            dec_neg = raw[31];
            if (exp_f == 8'hFF) begin
               // nan gives zero, infinity clamps
               dec_zero = (raw[22:0] != 23'd0);
               dec_sat  = (raw[22:0] == 23'd0);
            end else if (exp_f == 8'd0) begin
               // subnormal values are far below one output step
               dec_zero = 1'b1;
            end else if (exp_f >= 8'd127) begin
               dec_sat = 1'b1;
            end else begin
               mag_x      = {1'b1, raw[22:0], 8'h00};
               base_shift = 8'd158 - exp_f;
            end
         end
         FMT_PCM16: begin
            dec_neg    = raw[15];
            mag_x      = {16'd0, mag16};
            base_shift = 8'd15;
         end
         FMT_PCM24: begin
            dec_neg    = raw[23];
            mag_x      = {8'd0, mag24};
            base_shift = 8'd23;
         end
         FMT_PCM32: begin
            dec_neg    = raw[31];
            mag_x      = raw[31] ? (~raw + 32'd1) : raw;
            base_shift = 8'd31;
         end
         default: begin
            dec_zero = 1'b1;
         end
      endcase
      if (!dec_sat && mag_x == 32'd0) begin
         dec_zero = 1'b1;
      end
   end

   // leading one search
   always_comb begin
      lz = '0;
      for (int i = 0; i < 32; i++) begin
         if (mag_x[i]) begin
            lz = 5'(31 - i);
         end
      end
   end

   // normalize and round to 24 significant bits, nearest-even
   always_comb begin
      norm_x     = mag_x << lz;
      round_up   = norm_x[7] && ((norm_x[6:0] != 7'd0) || norm_x[8]);
      rounded    = {1'b0, norm_x[31:8]} + {24'd0, round_up};
      shift_full = {1'b0, base_shift} + {4'd0, lz} - 9'd8 - {8'd0, rounded[24]};
      dec_mant   = rounded[24] ? 24'h800000 : rounded[23:0];
      dec_shift  = shift_full[7:0];
   end

   assign dec = {dec_neg, dec_zero, dec_sat, dec_mant, dec_shift};

endmodule

`default_nettype wire

>>> rtl/pf2s_scale.sv
// scales a decoded sample by 32767 with 24-bit rounding and truncates to s16
`default_nettype none

module pf2s_scale (
   input  pf2s_pkg::dec_type  dec,
   output logic signed [15:0] sample
);
   import pf2s_pkg::*;

   logic [38:0] prod;
   logic [23:0] q_hi;
   logic        half;
   logic        sticky;
   logic        round_up;
   logic [24:0] q;
   logic [7:0]  k;
   logic [7:0]  dn;
   logic [24:0] mag_q;
   logic [14:0] mag;
   logic [15:0] mag16;

   // product by 32767 as a shift and subtract, then fixed-position rounding
   always_comb begin
      prod = {dec.mant, 15'd0} - {15'd0, dec.mant};
      if (prod[38]) begin
         q_hi   = prod[38:15];
         half   = prod[14];
         sticky = (prod[13:0] != 14'd0);
         k      = 8'd15;
      end else begin
         q_hi   = prod[37:14];
         half   = prod[13];
         sticky = (prod[12:0] != 13'd0);
         k      = 8'd14;
      end
      round_up = half && (sticky || q_hi[0]);
      q        = {1'b0, q_hi} + {24'd0, round_up};
   end

   // truncate toward zero, clamp and apply the sign
   always_comb begin
      dn = dec.shift - k;
      if (dn > 8'd24) begin
         mag_q = '0;
      end else begin
         mag_q = q >> dn[4:0];
      end
      if (dec.zero) begin
         mag = '0;
      end else if (dec.sat || mag_q > {10'd0, SAMPLE_MAX}) begin
         mag = SAMPLE_MAX;
      end else begin
         mag = mag_q[14:0];
      end
      mag16  = {1'b0, mag};
      sample = dec.neg ? (~mag16 + 16'd1) : mag16;
   end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// self-checking testbench for the pcm frame to s16 stereo converter
module testbench;
   import pf2s_pkg::*;

   // unsupported format codes and unused register indexes
   localparam logic [2:0] FMT_OTHER_MIN = 3'd4;
   localparam logic [2:0] FMT_OTHER_MAX = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 2'd3;
   localparam logic SRC_MONO   = 1'b0;
   localparam logic SRC_STEREO = 1'b1;
   localparam int IDLE_PCT   = 23;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES = 12;

   typedef struct {
      logic [31:0] first_raw;
      logic [31:0] second_raw;
      logic        packet_end;
   } frame_in_type;

   typedef struct {
      logic signed [15:0] left_s;
      logic signed [15:0] right_s;
      logic               packet_end;
   } stereo_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_first_raw = '0;
   logic [31:0] req_second_raw = '0;
   logic        req_packet_end = 1'b0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_left_sample;
   logic signed [15:0] rsp_right_sample;
   logic               rsp_packet_end_out;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the configuration registers
   logic [2:0] cfg_format = FMT_FLOAT32;
   logic       cfg_stereo = SRC_STEREO;

   frame_in_type    frames_pending[$];
   stereo_pair_type pairs_due[$];
   frame_in_type    next_frame;
   stereo_pair_type due_pair;
   stereo_pair_type got_pair;
   int              mismatches = 0;
   int              quiet_cycles = 0;
   logic            steady = 1'b0;

   // random part: format and source per phase
   logic [2:0] phase_fmt [PHASES] = '{FMT_FLOAT32, FMT_PCM16, FMT_PCM24, FMT_PCM32,
      FMT_OTHER_MIN, FMT_FLOAT32, FMT_PCM32, FMT_PCM24, FMT_OTHER_MAX, FMT_PCM16,
      FMT_FLOAT32, FMT_OTHER_MIN};
   logic phase_src [PHASES] = '{SRC_STEREO, SRC_STEREO, SRC_MONO, SRC_STEREO, SRC_STEREO,
      SRC_MONO, SRC_MONO, SRC_STEREO, SRC_MONO, SRC_MONO, SRC_STEREO, SRC_STEREO};

   pcm_frame_to_s16_stereo_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_raw      (req_first_raw),
      .req_second_raw     (req_second_raw),
      .req_packet_end     (req_packet_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_sample    (rsp_left_sample),
      .rsp_right_sample   (rsp_right_sample),
      .rsp_packet_end_out (rsp_packet_end_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // number of significant bits
   function automatic int unsigned sig_bits(logic [63:0] v);
      for (int i = 63; i >= 0; i--)
         if (v[i]) return i + 1;
      return 0;
   endfunction

   // keep 24 significant bits, nearest-even; drop gets the bits removed
   function automatic logic [63:0] round_to_24(input logic [63:0] v,
                                               output int unsigned drop);
      int unsigned n;
      int unsigned k;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      n = sig_bits(v);
      drop = 0;
      if (n <= 24) return v;
      k = n - 24;
      q = v >> k;
      rem = v & ((64'd1 << k) - 64'd1);
      half = 64'd1 << (k - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      drop = k;
      return q;
   endfunction

   // magnitude m * 2^-s times 32767, rounded to 24 bits, truncated, signed
   function automatic logic [15:0] scale_to_s16(logic neg, logic [63:0] m, int unsigned s);
      logic [63:0] q;
      logic [63:0] mag;
      int unsigned k;
      q = round_to_24(m * 64'd32767, k);
      if (k >= s) begin
         mag = (k - s >= 16) ? 64'd32767 : (q << (k - s));
         if (mag > 64'd32767) mag = 64'd32767;
      end else begin
         mag = (s - k >= 64) ? 64'd0 : (q >> (s - k));
      end
      if (neg) mag = -mag;
      return mag[15:0];
   endfunction

   // decode one raw sample word under the current format
   function automatic logic [15:0] to_s16(logic [31:0] w);
      logic [63:0] mag;
      logic [63:0] q;
      int unsigned k;
      case (cfg_format)
         FMT_FLOAT32: begin
            if (w[30:23] == 8'hFF) return (w[22:0] != 0) ? 16'd0 : scale_to_s16(w[31], 1, 0);
            if (w[30:23] == 8'h00) return scale_to_s16(w[31], {41'd0, w[22:0]}, 149);
            if (w[30:23] >= 8'd127) return scale_to_s16(w[31], 1, 0);
            return scale_to_s16(w[31], {40'd0, 1'b1, w[22:0]}, 150 - w[30:23]);
         end
         FMT_PCM16: begin
            mag = w[15] ? 64'h10000 - w[15:0] : {48'd0, w[15:0]};
            return scale_to_s16(w[15], mag, 15);
         end
         FMT_PCM24: begin
            mag = w[23] ? 64'h1000000 - w[23:0] : {40'd0, w[23:0]};
            return scale_to_s16(w[23], mag, 23);
         end
         FMT_PCM32: begin
            mag = w[31] ? 64'h100000000 - w : {32'd0, w};
            q = round_to_24(mag, k);
            return scale_to_s16(w[31], q << k, 31);
         end
         default: return 16'd0;
      endcase
   endfunction

   // random sample word biased toward the interesting regions of a format
   function automatic logic [31:0] pick_word(logic [2:0] fmt);
      logic [31:0] w;
      logic [31:0] tie;
      int unsigned mode;
      w = $urandom;
      mode = $urandom_range(9);
      tie = {2'b01, w[29:7], 7'h40};
      if (mode == 1) begin
         w = w >> $urandom_range(31);
      end else if (mode == 2) begin
         w = ~(w >> $urandom_range(31));
      end else if (mode >= 3) begin
         case (fmt)
            FMT_FLOAT32: begin
               if (mode == 3) begin
                  w[30:23] = 8'hFF;
                  if (w[0]) w[22:0] = '0;
               end else if (mode == 4) begin
                  w[30:23] = 8'h00;
               end else begin
                  w[30:23] = 8'($urandom_range(130, 100));
               end
            end
            FMT_PCM16:
               if (mode == 3) w[15:0] = w[15] ? {12'h800, w[3:0]} : {12'h7FF, w[3:0]};
            FMT_PCM24:
               if (mode == 3) w[23:0] = w[23] ? {20'h80000, w[3:0]} : {20'h7FFFF, w[3:0]};
            FMT_PCM32: begin
               if (mode == 3) w = w[31] ? {24'h800000, w[7:0]} : {24'h7FFFFF, w[7:0]};
               else if (mode == 4) w = w[31] ? -tie : tie;
            end
            default: ;
         endcase
      end
      return w;
   endfunction

   // request driver: predicts each frame on transfer, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_pair.left_s = to_s16(req_first_raw);
            due_pair.right_s = cfg_stereo ? to_s16(req_second_raw) : due_pair.left_s;
            due_pair.packet_end = req_packet_end;
            pairs_due.push_back(due_pair);
         end
         if (!req_valid || !req_stall) begin
            if (frames_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               next_frame = frames_pending[0];
               frames_pending.delete(0);
               req_valid <= 1'b1;
               req_first_raw <= next_frame.first_raw;
               req_second_raw <= next_frame.second_raw;
               req_packet_end <= next_frame.packet_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compares each transfer with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pairs_due.size() == 0) begin
               mismatches++;
               $display("%0t unexpected response: expected none, actual %0d %0d %0d",
                        $time, rsp_left_sample, rsp_right_sample, rsp_packet_end_out);
            end else begin
               got_pair = pairs_due[0];
               pairs_due.delete(0);
               if (rsp_left_sample !== got_pair.left_s) begin
                  mismatches++;
                  $display("%0t left_sample mismatch: expected %0d, actual %0d",
                           $time, got_pair.left_s, rsp_left_sample);
               end
               if (rsp_right_sample !== got_pair.right_s) begin
                  mismatches++;
                  $display("%0t right_sample mismatch: expected %0d, actual %0d",
                           $time, got_pair.right_s, rsp_right_sample);
               end
               if (rsp_packet_end_out !== got_pair.packet_end) begin
                  mismatches++;
                  $display("%0t packet_end_out mismatch: expected %0d, actual %0d",
                           $time, got_pair.packet_end, rsp_packet_end_out);
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one register write, mirrored into the local copy on transfer
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SAMPLE_FORMAT) cfg_format = data[2:0];
      else if (idx == CSR_STEREO_SOURCE) cfg_stereo = data[0];
   endtask

   // set format and source, with junk in the unused bits and indexes
   task automatic apply_config(logic [2:0] fmt, logic src);
      write_csr(CSR_SAMPLE_FORMAT, {5'($urandom), fmt});
      write_csr(CSR_STEREO_SOURCE, {7'($urandom), src});
      write_csr($urandom_range(1) ? CSR_UNUSED_LO : CSR_UNUSED_HI, 8'($urandom));
      @(negedge clock);
   endtask

   task automatic queue_frame(logic [31:0] first, logic [31:0] second, logic pend);
      frame_in_type f;
      f.first_raw = first;
      f.second_raw = second;
      f.packet_end = pend;
      frames_pending.push_back(f);
   endtask

   // wait until every frame is sent and every response is back
   task automatic drain_frames();
      do @(negedge clock);
      while (frames_pending.size() != 0 || req_valid || pairs_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [2:0] fmt;
      int count;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // float32 after reset: zeros, full scale, infinities, nan, tiny values
      queue_frame(32'h0000_0000, 32'h8000_0000, 1'b0);
      queue_frame(32'h3F80_0000, 32'hBF80_0000, 1'b1);
      queue_frame(32'h7F80_0000, 32'hFF80_0000, 1'b0);
      queue_frame(32'h7FC0_0000, 32'hFF80_0001, 1'b1);
      queue_frame(32'h0000_0001, 32'h807F_FFFF, 1'b0);
      queue_frame(32'h7F7F_FFFF, 32'h3F7F_FFFF, 1'b1);
      queue_frame(32'h3300_0000, 32'hBEFF_FFFF, 1'b0);
      drain_frames();

      // pcm16 extremes and ignored high bits
      apply_config(FMT_PCM16, SRC_STEREO);
      queue_frame(32'hFFFF_7FFF, 32'h0000_8000, 1'b1);
      queue_frame(32'h1234_0000, 32'hABCD_0001, 1'b0);
      queue_frame(32'h0000_FFFF, 32'hFFFF_FFFF, 1'b1);
      drain_frames();

      // pcm24 extremes and ignored high bits
      apply_config(FMT_PCM24, SRC_STEREO);
      queue_frame(32'h007F_FFFF, 32'hFF80_0000, 1'b1);
      queue_frame(32'hAB00_0001, 32'h00FF_FFFF, 1'b0);
      drain_frames();

      // pcm32 extremes and a rounding tie
      apply_config(FMT_PCM32, SRC_STEREO);
      queue_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      queue_frame(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
      queue_frame(32'h7FFF_FFC0, 32'h4000_0040, 1'b1);
      drain_frames();

      // unsupported codes give silence
      apply_config(FMT_OTHER_MIN, SRC_STEREO);
      queue_frame(32'hFFFF_FFFF, 32'h3F80_0000, 1'b1);
      drain_frames();
      apply_config(FMT_OTHER_MAX, SRC_MONO);
      queue_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      drain_frames();

      // mono source copies left to right
      apply_config(FMT_FLOAT32, SRC_MONO);
      queue_frame(32'h3F80_0000, 32'hBF80_0000, 1'b1);
      drain_frames();
      apply_config(FMT_PCM16, SRC_MONO);
      queue_frame(32'h0000_8000, 32'h0000_7FFF, 1'b0);
      drain_frames();

      // random frames, one phase per setting, each phase drained before the next
      for (int p = 0; p < PHASES; p++) begin
         fmt = phase_fmt[p];
         if (p == PHASES - 1) fmt = 3'($urandom_range(FMT_OTHER_MAX, FMT_OTHER_MIN));
         apply_config(fmt, phase_src[p]);
         steady = (p == 5);
         count = (fmt >= FMT_OTHER_MIN) ? 50 : 190;
         for (int i = 0; i < count; i++)
            queue_frame(pick_word(fmt), pick_word(fmt), 1'($urandom));
         drain_frames();
         steady = 1'b0;
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
